@@ rtl/core/hsvrgb_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

    localparam int HUE_BITS    = 11;
    localparam int FRAC_BITS   = 8;
    localparam int SECTOR_BITS = 3;

    localparam logic [FRAC_BITS:0]   FRAC_ONE  = 9'd256;
    localparam logic [FRAC_BITS-1:0] FRAC_HALF = 8'd128;

    localparam logic [SECTOR_BITS-1:0] SECTOR_COUNT = 3'd6;
    localparam logic [SECTOR_BITS-1:0] SEC_0 = 3'd0;
    localparam logic [SECTOR_BITS-1:0] SEC_1 = 3'd1;
    localparam logic [SECTOR_BITS-1:0] SEC_2 = 3'd2;
    localparam logic [SECTOR_BITS-1:0] SEC_3 = 3'd3;
    localparam logic [SECTOR_BITS-1:0] SEC_4 = 3'd4;

    typedef struct packed {
        logic                   valid;
        logic                   gray;
        logic [SECTOR_BITS-1:0] sector;
    } hsvrgb_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/hsvrgb_front.sv @@
// Front stages: sector reduction and rounded saturation-fraction products.
`default_nettype none

module hsvrgb_front #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en1,
    input  wire logic                                 en2,
    input  wire logic                                 in_valid,
    input  wire logic [hsvrgb_pkg::HUE_BITS-1:0]      hue,
    input  wire logic [CHANNEL_BITS-1:0]              saturation,
    input  wire logic [CHANNEL_BITS-1:0]              brightness,
    output logic                                      st1_valid,
    output hsvrgb_pkg::hsvrgb_ctrl_t                  ctrl2,
    output logic [CHANNEL_BITS-1:0]                   sat2,
    output logic [CHANNEL_BITS-1:0]                   val2,
    output logic [CHANNEL_BITS-1:0]                   sf2,
    output logic [CHANNEL_BITS-1:0]                   sg2
);

    localparam int PW = CHANNEL_BITS + hsvrgb_pkg::FRAC_BITS + 1;

    hsvrgb_pkg::hsvrgb_ctrl_t ctrl1_reg, ctrl1_next, ctrl2_reg;
    logic [hsvrgb_pkg::SECTOR_BITS-1:0] sec_raw;
    logic [hsvrgb_pkg::SECTOR_BITS-1:0] sec_mod;
    logic [hsvrgb_pkg::FRAC_BITS-1:0]   frac1_reg;
    logic [hsvrgb_pkg::FRAC_BITS:0]     frac_comp;
    logic [CHANNEL_BITS-1:0]            sat1_reg, val1_reg;
    logic [CHANNEL_BITS-1:0]            sat2_reg, val2_reg;
    logic [CHANNEL_BITS-1:0]            sf_next, sg_next, sf2_reg, sg2_reg;
    logic [PW-1:0]                      sf_prod, sg_prod;

    // fold sectors six and seven back onto zero and one
    always_comb
    begin
        sec_raw = hue[hsvrgb_pkg::HUE_BITS-1 -: hsvrgb_pkg::SECTOR_BITS];
        if (sec_raw >= hsvrgb_pkg::SECTOR_COUNT)
        begin
            sec_mod = sec_raw - hsvrgb_pkg::SECTOR_COUNT;
        end
        else
        begin
            sec_mod = sec_raw;
        end
        ctrl1_next.valid  = in_valid;
        ctrl1_next.gray   = (saturation == '0);
        ctrl1_next.sector = sec_mod;
    end

    always_comb
    begin
        frac_comp = hsvrgb_pkg::FRAC_ONE - {1'b0, frac1_reg};
        sf_prod   = PW'(sat1_reg) * PW'(frac1_reg) + PW'(hsvrgb_pkg::FRAC_HALF);
        sg_prod   = PW'(sat1_reg) * PW'(frac_comp) + PW'(hsvrgb_pkg::FRAC_HALF);
        sf_next   = sf_prod[hsvrgb_pkg::FRAC_BITS +: CHANNEL_BITS];
        sg_next   = sg_prod[hsvrgb_pkg::FRAC_BITS +: CHANNEL_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end
        else
        begin
            if (en1)
            begin
                ctrl1_reg <= ctrl1_next;
            end
            if (en2)
            begin
                ctrl2_reg <= ctrl1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            frac1_reg <= hue[hsvrgb_pkg::FRAC_BITS-1:0];
            sat1_reg  <= saturation;
            val1_reg  <= brightness;
        end
        if (en2)
        begin
            sat2_reg <= sat1_reg;
            val2_reg <= val1_reg;
            sf2_reg  <= sf_next;
            sg2_reg  <= sg_next;
        end
    end

    assign st1_valid = ctrl1_reg.valid;
    assign ctrl2     = ctrl2_reg;
    assign sat2      = sat2_reg;
    assign val2      = val2_reg;
    assign sf2       = sf2_reg;
    assign sg2       = sg2_reg;

endmodule

`default_nettype wire

@@ rtl/core/hsvrgb_lane.sv @@
// One scaling lane: v*(M-k) plus half of M, then a coarse quotient by M.
`default_nettype none

module hsvrgb_lane #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        en3,
    input  wire logic                        en4,
    input  wire logic [CHANNEL_BITS-1:0]     val,
    input  wire logic [CHANNEL_BITS-1:0]     k,
    output logic [2*CHANNEL_BITS-1:0]        z4,
    output logic [CHANNEL_BITS:0]            quo4
);

    localparam int ZW = 2 * CHANNEL_BITS;
    localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = '1;
    localparam logic [ZW-1:0] HALF_M = ZW'((64'd1 << (CHANNEL_BITS - 1)) - 64'd1);

    logic [CHANNEL_BITS-1:0] comp;
    logic [ZW-1:0]           z_next, z3_reg, z4_reg;
    logic [ZW:0]             approx;
    logic [CHANNEL_BITS:0]   quo_next, quo4_reg;

    always_comb
    begin
        comp   = CHAN_MAX - k;
        z_next = ZW'(val) * ZW'(comp) + HALF_M;
    end

    // z/M ~ (z + z/2^N)/2^N, low by at most one
    always_comb
    begin
        approx   = (ZW + 1)'(z3_reg) + (ZW + 1)'(z3_reg >> CHANNEL_BITS);
        quo_next = approx[CHANNEL_BITS +: CHANNEL_BITS + 1];
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            z3_reg <= z_next;
        end
        if (en4)
        begin
            z4_reg   <= z3_reg;
            quo4_reg <= quo_next;
        end
    end

    assign z4   = z4_reg;
    assign quo4 = quo4_reg;

endmodule

`default_nettype wire

@@ rtl/core/hsvrgb_back.sv @@
// Back stage: quotient correction, sector permutation and output register.
`default_nettype none

module hsvrgb_back #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en_out,
    input  wire hsvrgb_pkg::hsvrgb_ctrl_t      ctrl4,
    input  wire logic [CHANNEL_BITS-1:0]       val4,
    input  wire logic [2*CHANNEL_BITS-1:0]     zp,
    input  wire logic [CHANNEL_BITS:0]         qp,
    input  wire logic [2*CHANNEL_BITS-1:0]     zq,
    input  wire logic [CHANNEL_BITS:0]         qq,
    input  wire logic [2*CHANNEL_BITS-1:0]     zt,
    input  wire logic [CHANNEL_BITS:0]         qt,
    output logic                               out_valid,
    output logic [CHANNEL_BITS-1:0]            red,
    output logic [CHANNEL_BITS-1:0]            green,
    output logic [CHANNEL_BITS-1:0]            blue
);

    localparam int RW = 2 * CHANNEL_BITS + 1;
    localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = '1;

    logic                    valid_reg;
    logic [CHANNEL_BITS-1:0] p_val, q_val, t_val;
    logic [CHANNEL_BITS-1:0] red_next, green_next, blue_next;
    logic [CHANNEL_BITS-1:0] red_reg, green_reg, blue_reg;

    // bump the coarse quotient when the remainder reaches M
    function automatic logic [CHANNEL_BITS-1:0] fix_quo(
        input logic [2*CHANNEL_BITS-1:0] z,
        input logic [CHANNEL_BITS:0]     q1
    );
        logic [RW-1:0] rem;
        rem = RW'(z) - (RW'(q1) << CHANNEL_BITS) + RW'(q1);
        if (rem >= RW'(CHAN_MAX))
        begin
            return CHANNEL_BITS'(q1 + 1'b1);
        end
        return CHANNEL_BITS'(q1);
    endfunction

    always_comb
    begin
        p_val = fix_quo(zp, qp);
        q_val = fix_quo(zq, qq);
        t_val = fix_quo(zt, qt);
        if (ctrl4.gray)
        begin
            red_next   = val4;
            green_next = val4;
            blue_next  = val4;
        end
        else
        begin
            unique case (ctrl4.sector)
                hsvrgb_pkg::SEC_0:
                begin
                    red_next = val4;  green_next = t_val; blue_next = p_val;
                end
                hsvrgb_pkg::SEC_1:
                begin
                    red_next = q_val; green_next = val4;  blue_next = p_val;
                end
                hsvrgb_pkg::SEC_2:
                begin
                    red_next = p_val; green_next = val4;  blue_next = t_val;
                end
                hsvrgb_pkg::SEC_3:
                begin
                    red_next = p_val; green_next = q_val; blue_next = val4;
                end
                hsvrgb_pkg::SEC_4:
                begin
                    red_next = t_val; green_next = p_val; blue_next = val4;
                end
                default:
                begin
                    // sector five
                    red_next = val4;  green_next = p_val; blue_next = q_val;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            valid_reg <= ctrl4.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

`default_nettype wire

@@ rtl/core/hsv_to_rgb_converter_top.sv @@
// Top level of the pipelined HSV to RGB pixel converter.
//
// Input channel: in_valid / in_stall carry one HSV word (hue, saturation,
// brightness). A word is taken at a rising edge with in_valid high and
// in_stall low. Hue is sector*256 + fraction; 1536 is a full turn.
// Output channel: out_valid / out_stall carry one RGB word (red, green, blue),
// taken at a rising edge with out_valid high and out_stall low.
// Throughput: one word per cycle while out_stall stays low, set by the five
// register stages each advancing unless held; no stage iterates.
// Depth: five register stages between the input word and out_valid.
// Stages: input register, fraction products, v*(M-k) lanes, coarse divide
// by M, then correction plus permutation into the output register.
// Stall: each stage holds while the stage after it is full and held, so a
// stalled receiver backs the pipe up word by word; bubbles collapse, and
// in_stall rises only when every stage is full. Nothing is dropped or doubled.
// Reset: rst_n clears all valid bits at once; payload registers keep garbage
// until loaded. No configuration and no clearing pass.
`default_nettype none

module hsv_to_rgb_converter_top #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [hsvrgb_pkg::HUE_BITS-1:0]  hue,
    input  wire logic [CHANNEL_BITS-1:0]          saturation,
    input  wire logic [CHANNEL_BITS-1:0]          brightness,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [CHANNEL_BITS-1:0]               red,
    output logic [CHANNEL_BITS-1:0]               green,
    output logic [CHANNEL_BITS-1:0]               blue
);

    localparam int ZW = 2 * CHANNEL_BITS;

    logic en1, en2, en3, en4, en_out;
    logic st1_valid;

    hsvrgb_pkg::hsvrgb_ctrl_t ctrl2, ctrl3_reg, ctrl4_reg;

    logic [CHANNEL_BITS-1:0] sat2, val2, sf2, sg2;
    logic [CHANNEL_BITS-1:0] val3_reg, val4_reg;
    logic [ZW-1:0]           zp, zq, zt;
    logic [CHANNEL_BITS:0]   qp, qq, qt;

    // A stage loads when it is empty or when the stage after it loads too.
    always_comb
    begin
        en_out   = !out_valid || !out_stall;
        en4      = !ctrl4_reg.valid || en_out;
        en3      = !ctrl3_reg.valid || en4;
        en2      = !ctrl2.valid || en3;
        en1      = !st1_valid || en2;
        in_stall = !en1;
    end

    hsvrgb_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en1        (en1),
        .en2        (en2),
        .in_valid   (in_valid),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .st1_valid  (st1_valid),
        .ctrl2      (ctrl2),
        .sat2       (sat2),
        .val2       (val2),
        .sf2        (sf2),
        .sg2        (sg2)
    );

    // p scales by s, q by sf, t by sg
    hsvrgb_lane #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lane_p (
        .clk  (clk),
        .en3  (en3),
        .en4  (en4),
        .val  (val2),
        .k    (sat2),
        .z4   (zp),
        .quo4 (qp)
    );

    hsvrgb_lane #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lane_q (
        .clk  (clk),
        .en3  (en3),
        .en4  (en4),
        .val  (val2),
        .k    (sf2),
        .z4   (zq),
        .quo4 (qq)
    );

    hsvrgb_lane #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lane_t (
        .clk  (clk),
        .en3  (en3),
        .en4  (en4),
        .val  (val2),
        .k    (sg2),
        .z4   (zt),
        .quo4 (qt)
    );

    // Carry valid, gray flag and sector alongside the lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
        end
        else
        begin
            if (en3)
            begin
                ctrl3_reg <= ctrl2;
            end
            if (en4)
            begin
                ctrl4_reg <= ctrl3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            val3_reg <= val2;
        end
        if (en4)
        begin
            val4_reg <= val3_reg;
        end
    end

    hsvrgb_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en_out    (en_out),
        .ctrl4     (ctrl4_reg),
        .val4      (val4_reg),
        .zp        (zp),
        .qp        (qp),
        .zq        (zq),
        .qq        (qq),
        .zt        (zt),
        .qt        (qt),
        .out_valid (out_valid),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

`default_nettype wire

@@ bench/hsv_to_rgb_converter_top_tb.sv @@
// Self-checking testbench for the HSV to RGB pixel converter: directed, stall and random tests.
`default_nettype none

module hsv_to_rgb_converter_top_tb;

    localparam int          CHANNEL_BITS = 8;
    localparam int unsigned CHAN_MAX     = (1 << CHANNEL_BITS) - 1;
    localparam int unsigned HUE_TURN     = 1536;
    localparam int unsigned HUE_TOP      = (1 << hsvrgb_pkg::HUE_BITS) - 1;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          RANDOM_WORDS = 1500;

    typedef logic [hsvrgb_pkg::HUE_BITS-1:0] hue_word_t;
    typedef logic [CHANNEL_BITS-1:0]         chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_word_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    hue_word_t hue = '0;
    chan_t     saturation = '0;
    chan_t     brightness = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    chan_t     red;
    chan_t     green;
    chan_t     blue;

    // Expected RGB words, oldest first, pushed when the input word is taken.
    rgb_word_t   rgb_expected_q[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    // Both sides stop idling while this is set.
    bit          steady = 1'b0;
    // Request a receiver hold-off of this many cycles; the receiver clears it.
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_left = 0;

    hsv_to_rgb_converter_top #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .hue       (hue),
        .saturation(saturation),
        .brightness(brightness),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // v * (M - k) / M, rounded to nearest with halves going up.
    function automatic chan_t shade(input chan_t v, input int unsigned k);
        int unsigned num;
        num = 2 * v * (CHAN_MAX - k) + CHAN_MAX;
        return chan_t'(num / (2 * CHAN_MAX));
    endfunction

    // Compute the RGB word the converter must produce for one HSV word.
    function automatic rgb_word_t predict_rgb(input hue_word_t h, input chan_t s,
                                              input chan_t v);
        logic [hsvrgb_pkg::SECTOR_BITS-1:0] sector;
        int unsigned                        frac;
        int unsigned                        sf;
        int unsigned                        sg;
        chan_t                              p;
        chan_t                              q;
        chan_t                              t;
        rgb_word_t                          rgb;
        // Sectors 6 and 7 wrap onto 0 and 1; the fraction is kept as given.
        sector = h[hsvrgb_pkg::HUE_BITS-1:hsvrgb_pkg::FRAC_BITS] % hsvrgb_pkg::SECTOR_COUNT;
        frac   = h[hsvrgb_pkg::FRAC_BITS-1:0];
        if (s == '0)
        begin
            rgb = '{v, v, v};
        end
        else
        begin
            sf = (s * frac + hsvrgb_pkg::FRAC_HALF) >> hsvrgb_pkg::FRAC_BITS;
            sg = (s * (hsvrgb_pkg::FRAC_ONE - frac) + hsvrgb_pkg::FRAC_HALF)
                 >> hsvrgb_pkg::FRAC_BITS;
            p  = shade(v, s);
            q  = shade(v, sf);
            t  = shade(v, sg);
            case (sector)
                hsvrgb_pkg::SEC_0: rgb = '{v, t, p};
                hsvrgb_pkg::SEC_1: rgb = '{q, v, p};
                hsvrgb_pkg::SEC_2: rgb = '{p, v, t};
                hsvrgb_pkg::SEC_3: rgb = '{p, q, v};
                hsvrgb_pkg::SEC_4: rgb = '{t, p, v};
                default:           rgb = '{v, p, q};
            endcase
        end
        return rgb;
    endfunction

    // Offer one word and hold it until taken; leave in_valid high on return so
    // a following word goes out back to back. Call right after a rising edge.
    task automatic send_pixel(input hue_word_t h, input chan_t s, input chan_t v);
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        do
            @(posedge clk);
        while (in_stall);
        rgb_expected_q.push_back(predict_rgb(h, s, v));
    endtask

    // Drop valid for a few cycles now and then, scrambling the idle payload.
    task automatic sender_gap();
        if (!steady && $urandom_range(99) < 4)
        begin
            in_valid   <= 1'b0;
            hue        <= hue_word_t'($urandom);
            saturation <= chan_t'($urandom);
            brightness <= chan_t'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (rgb_expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Bias a channel level toward its extremes.
    function automatic chan_t pick_level();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        else if (roll < 16)
            return chan_t'(CHAN_MAX);
        return chan_t'($urandom);
    endfunction

    // Corners: zero and full saturation, each sector, full turn, hue past a turn.
    task automatic test_directed();
        send_pixel(11'd0,    8'd0,   8'd0);
        send_pixel(11'd0,    8'd255, 8'd255);
        send_pixel(11'd700,  8'd0,   8'd200);
        send_pixel(11'd256,  8'd255, 8'd255);
        send_pixel(11'd512,  8'd255, 8'd255);
        send_pixel(11'd768,  8'd255, 8'd255);
        send_pixel(11'd1024, 8'd255, 8'd255);
        send_pixel(11'd1280, 8'd255, 8'd255);
        send_pixel(11'd1535, 8'd255, 8'd255);
        send_pixel(11'(HUE_TURN), 8'd255, 8'd255);
        send_pixel(11'd1664, 8'd200, 8'd180);
        send_pixel(11'd1920, 8'd255, 8'd255);
        send_pixel(11'(HUE_TOP), 8'd255, 8'd255);
        send_pixel(11'd255,  8'd255, 8'd255);
        send_pixel(11'd896,  8'd128, 8'd255);
        send_pixel(11'd128,  8'd1,   8'd255);
        send_pixel(11'd1000, 8'd255, 8'd1);
        send_pixel(11'd1279, 8'd128, 8'd77);
        send_pixel(11'd1408, 8'd254, 8'd254);
        send_pixel(11'd2000, 8'd0,   8'd0);
        wait_drained();
    endtask

    // Hold the receiver off long enough for the pipe to fill and stall the
    // input, keep offering words throughout, pause until all are back, then send and drain a second batch.
    task automatic test_backpressure();
        rx_hold_req = 80;
        @(posedge clk);
        repeat (40)
            send_pixel(hue_word_t'($urandom_range(0, HUE_TURN)), pick_level(), pick_level());
        wait_drained();
        repeat (10)
            send_pixel(hue_word_t'($urandom_range(0, HUE_TURN)), pick_level(), pick_level());
        wait_drained();
    endtask

    // Random words; most hues stay inside one turn, the rest go past it.
    // A middle stretch runs with no idling on either side.
    task automatic test_random();
        hue_word_t h;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            steady = (i >= 500 && i < 900);
            if ($urandom_range(99) < 15)
                h = hue_word_t'($urandom_range(HUE_TURN + 1, HUE_TOP));
            else
                h = hue_word_t'($urandom_range(0, HUE_TURN));
            send_pixel(h, pick_level(), pick_level());
            sender_gap();
        end
        steady = 1'b0;
        wait_drained();
    endtask

    // Receiver: serve hold-off requests, otherwise stall at random.
    always @(posedge clk)
    begin
        if (rx_hold_req != 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0)
        begin
            out_stall <= 1'b1;
            rx_hold_left--;
        end
        else if (steady)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 10);
    end

    // Compare each accepted output word against the oldest expectation.
    always @(posedge clk)
    begin
        rgb_word_t exp_rgb;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rgb_expected_q.size() == 0)
            begin
                $error("unexpected output word: red %0d green %0d blue %0d",
                       red, green, blue);
                mismatch_count++;
            end
            else
            begin
                exp_rgb = rgb_expected_q.pop_front();
                if (red !== exp_rgb.red)
                begin
                    $error("red: expected %0d, got %0d", exp_rgb.red, red);
                    mismatch_count++;
                end
                if (green !== exp_rgb.green)
                begin
                    $error("green: expected %0d, got %0d", exp_rgb.green, green);
                    mismatch_count++;
                end
                if (blue !== exp_rgb.blue)
                begin
                    $error("blue: expected %0d, got %0d", exp_rgb.blue, blue);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        // Hold reset at start, then release it once.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random();

        // Let any stray word surface before judging.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && rgb_expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

@@ hsv_to_rgb_converter_top.f @@
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_front.sv
rtl/core/hsvrgb_lane.sv
rtl/core/hsvrgb_back.sv
rtl/core/hsv_to_rgb_converter_top.sv
bench/hsv_to_rgb_converter_top_tb.sv
